/* rtl/bspu_pkg.sv */
// Shared types, codes and constants of the bit stream packer and unpacker.
package bspu_pkg;

  localparam int BYTE_W         = 8;
  localparam int VALUE_W        = 24;
  localparam int COUNT_W        = 5;
  localparam int STATUS_W       = 2;
  localparam int MAX_FIELD_BITS = 24;
  // A field of up to 24 bits at a bit offset of up to 7 fits in four bytes.
  localparam int WIN_W          = 32;
  localparam int IDX_W          = 2;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_WR_OVF   = 2'd1,
    STS_RD_PAST  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             wr_byte;
    logic             rd_byte;
    logic             cap;
    logic             commit;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] cap_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             new_is_read;
    logic             new_err;
    logic [IDX_W-1:0] last_idx;
  } dp_sts_t;

  function automatic logic [WIN_W-1:0] field_mask(input logic [COUNT_W-1:0] count);
    field_mask = ~({WIN_W{1'b1}} << count);
  endfunction

endpackage

/* rtl/bit_stream_packer_unpacker.sv */
// Top level of the LSB-first bit stream packer and unpacker.
//
// One input stream carries commands: tuser selects append (0) or read (1),
// tdata carries the value and the bit count (1 to 24). Every command gives
// exactly one item on the output stream with the extracted bits and a status:
// ok, write overflow (write dropped) or read past the written data (zero
// returned, read pointer kept).
// Items are handled one at a time. An append writes, and a read reads, in turn
// each of the store bytes (1 to 4) that the field touches; a rejected command
// goes straight to its result. This one-by-one access is forced by the single
// byte-wide store port, which moves one byte a cycle.
// The result sits in an output register, so the next command is accepted while
// it waits; a stalled receiver holds the block only once a second result is
// ready. Reset clears both pointers and the partial tail byte; the store needs
// no clearing, since bytes at or past the write pointer are never read.
module bit_stream_packer_unpacker #(
  parameter int CAPACITY_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[23:0], bit_count[28:24], zero pad
  input  logic [0:0]  s_axis_tuser,  // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // read_value[23:0], status[25:24], zero pad
);

  bspu_pkg::dp_cmd_t cmd;
  bspu_pkg::dp_sts_t sts;

  logic [bspu_pkg::VALUE_W-1:0]  read_value;
  logic [bspu_pkg::STATUS_W-1:0] status;

  bspu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bspu_dp #(
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (s_axis_tuser[0]),
    .value_i      (s_axis_tdata[23:0]),
    .bit_count_i  (s_axis_tdata[28:24]),
    .read_value_o (read_value),
    .status_o     (status)
  );

  assign m_axis_tdata = {6'b000000, status, read_value};

endmodule

/* rtl/bspu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bspu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bspu_dp.sv */
// Datapath: pointers, tail byte, four-byte window, byte store and result register.
module bspu_dp #(
  parameter int CAPACITY_BITS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bspu_pkg::dp_cmd_t                cmd_i,
  output bspu_pkg::dp_sts_t                sts_o,
  input  logic                             opcode_i,
  input  logic [bspu_pkg::VALUE_W-1:0]     value_i,
  input  logic [bspu_pkg::COUNT_W-1:0]     bit_count_i,
  output logic [bspu_pkg::VALUE_W-1:0]     read_value_o,
  output logic [bspu_pkg::STATUS_W-1:0]    status_o
);

  localparam int DEPTH = (CAPACITY_BITS + bspu_pkg::BYTE_W - 1) / bspu_pkg::BYTE_W;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(CAPACITY_BITS + 1);
  localparam int WW    = bspu_pkg::WIN_W;
  localparam int BW    = bspu_pkg::BYTE_W;

  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [BW-1:0]  tail_q, tail_d;

  logic                           op_q;
  logic                           err_q;
  logic [bspu_pkg::COUNT_W-1:0]   cnt_q;
  logic [2:0]                     off_q;
  logic [5:0]                     span_q;
  logic [bspu_pkg::IDX_W-1:0]     last_q;
  logic [AW-1:0]                  base_q;
  logic [WW-1:0]                  win_q;

  logic [bspu_pkg::VALUE_W-1:0]   result_q;
  bspu_pkg::status_e              status_q;

  logic          cnt_ok, is_rd, wr_err, rd_err;
  logic [PW:0]   wr_end, rd_end;
  logic [2:0]    off;
  logic [5:0]    span, span_m1;
  logic [WW-1:0] val_win;
  logic [BW-1:0] rdata;
  logic [AW-1:0] addr;

  // Checks and window set-up for the item at the input.
  always_comb begin
    cnt_ok  = (bit_count_i != '0) &&
              (bit_count_i <= bspu_pkg::COUNT_W'(bspu_pkg::MAX_FIELD_BITS));
    is_rd   = (bspu_pkg::op_e'(opcode_i) == bspu_pkg::OP_READ);
    wr_end  = {1'b0, wp_q} + (PW+1)'(bit_count_i);
    rd_end  = {1'b0, rp_q} + (PW+1)'(bit_count_i);
    wr_err  = !cnt_ok || (wr_end > (PW+1)'(CAPACITY_BITS));
    rd_err  = !cnt_ok || (rd_end > {1'b0, wp_q});
    off     = is_rd ? rp_q[2:0] : wp_q[2:0];
    span    = {3'b000, off} + {1'b0, bit_count_i};
    span_m1 = span - 6'd1;
    val_win = (WW'(value_i) & bspu_pkg::field_mask(bit_count_i)) << off;
  end

  assign sts_o.new_is_read = is_rd;
  assign sts_o.new_err     = is_rd ? rd_err : wr_err;
  assign sts_o.last_idx    = last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      err_q  <= is_rd ? rd_err : wr_err;
      cnt_q  <= bit_count_i;
      off_q  <= off;
      span_q <= span;
      last_q <= span_m1[4:3];
      base_q <= is_rd ? AW'(rp_q >> 3) : AW'(wp_q >> 3);
      // The tail byte carries the bits already written in the partial byte.
      win_q  <= is_rd ? '0 : (WW'(tail_q) | val_win);
    end else if (cmd_i.cap) begin
      win_q[{cmd_i.cap_idx, 3'b000} +: BW] <= rdata;
    end
  end

  // Pointer and tail updates at the end of an item.
  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    tail_d = tail_q;
    if (cmd_i.commit && !err_q) begin
      if (bspu_pkg::op_e'(op_q) == bspu_pkg::OP_READ) begin
        rp_d = rp_q + PW'(cnt_q);
      end else begin
        wp_d   = wp_q + PW'(cnt_q);
        tail_d = (span_q[2:0] == 3'b000) ? '0 : win_q[{span_q[4:3], 3'b000} +: BW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      tail_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (err_q) begin
        result_q <= '0;
        status_q <= (bspu_pkg::op_e'(op_q) == bspu_pkg::OP_READ) ?
                    bspu_pkg::STS_RD_PAST : bspu_pkg::STS_WR_OVF;
      end else if (bspu_pkg::op_e'(op_q) == bspu_pkg::OP_READ) begin
        result_q <= bspu_pkg::VALUE_W'((win_q >> off_q) & bspu_pkg::field_mask(cnt_q));
        status_q <= bspu_pkg::STS_OK;
      end else begin
        result_q <= '0;
        status_q <= bspu_pkg::STS_OK;
      end
    end
  end

  assign addr = base_q + AW'(cmd_i.idx);

  bspu_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_byte),
    .waddr_i (addr),
    .wdata_i (win_q[{cmd_i.idx, 3'b000} +: BW]),
    .re_i    (cmd_i.rd_byte),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign read_value_o = result_q;
  assign status_o     = status_q;

endmodule

/* rtl/bspu_ctrl.sv */
// Controller: sequences the byte accesses of one item and owns both handshakes.
module bspu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output bspu_pkg::dp_cmd_t cmd_o,
  input  bspu_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [bspu_pkg::IDX_W-1:0] k_q;
  logic                       cap_vld_q;
  logic [bspu_pkg::IDX_W-1:0] cap_k_q;
  logic                       out_valid_q;
  logic                       slot_free;

  assign slot_free  = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.idx     = k_q;
    cmd_o.cap     = cap_vld_q;
    cmd_o.cap_idx = cap_k_q;
    case (state_q)
      S_IDLE:  cmd_o.load    = s_tvalid_i;
      S_WRITE: cmd_o.wr_byte = 1'b1;
      S_READ:  cmd_o.rd_byte = 1'b1;
      S_DONE:  cmd_o.commit  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      cap_vld_q   <= 1'b0;
      cap_k_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_vld_q <= 1'b0;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          k_q <= '0;
          if (s_tvalid_i) begin
            if (sts_i.new_err) begin
              state_q <= S_DONE;
            end else if (sts_i.new_is_read) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (k_q == sts_i.last_idx) begin
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + bspu_pkg::IDX_W'(1);
          end
        end
        S_READ: begin
          // Read data arrives in the cycle after the address is issued.
          cap_vld_q <= 1'b1;
          cap_k_q   <= k_q;
          if (k_q == sts_i.last_idx) begin
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + bspu_pkg::IDX_W'(1);
          end
        end
        S_DRAIN: state_q <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.wr_byte, cmd_o.rd_byte, cmd_o.commit}))
    else $error("more than one datapath command in a cycle");

  a_cap_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_vld_q |-> $past(cmd_o.rd_byte))
    else $error("capture without a preceding store read");

  a_idx_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_byte || cmd_o.rd_byte) |-> (k_q <= sts_i.last_idx))
    else $error("byte index beyond the span of the item");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

endmodule

/* sim/bspu_stream_checker.sv */
// Checker that predicts every result of the bit stream packer and compares it.
module bspu_stream_checker #(
  parameter int CAPACITY_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,   // value[23:0], bit_count[28:24], zero pad
  input  logic [0:0]  in_user_i,   // opcode[0]
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,  // read_value[23:0], status[25:24], zero pad
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [bspu_pkg::VALUE_W-1:0] read_value;
    bspu_pkg::status_e            status;
  } stream_result_t;

  logic [CAPACITY_BITS-1:0]     stream_bits;
  int                           wr_pos;
  int                           rd_pos;
  stream_result_t               pending_results[$];
  stream_result_t               want;
  logic [bspu_pkg::VALUE_W-1:0] got_value;
  bspu_pkg::status_e            got_status;
  int                           mismatch_count;

  // Works out the result of one command and advances the shadow buffer.
  function automatic stream_result_t stream_result(
    input bspu_pkg::op_e                op,
    input logic [bspu_pkg::VALUE_W-1:0] val,
    input logic [bspu_pkg::COUNT_W-1:0] cnt
  );
    stream_result_t res;
    logic           count_ok;
    int             i;
    res.read_value = '0;
    res.status     = bspu_pkg::STS_OK;
    count_ok       = (cnt >= 1) && (cnt <= bspu_pkg::MAX_FIELD_BITS);
    if (op == bspu_pkg::OP_APPEND) begin
      if (!count_ok || (wr_pos + int'(cnt) > CAPACITY_BITS)) begin
        res.status = bspu_pkg::STS_WR_OVF;
      end else begin
        // Bits are written once each, so setting them equals OR into zeros.
        for (i = 0; i < int'(cnt); i++) begin
          if (val[i]) stream_bits[wr_pos + i] = 1'b1;
        end
        wr_pos = wr_pos + int'(cnt);
      end
    end else begin
      if (!count_ok || (rd_pos + int'(cnt) > wr_pos)) begin
        res.status = bspu_pkg::STS_RD_PAST;
      end else begin
        for (i = 0; i < int'(cnt); i++) begin
          res.read_value[i] = stream_bits[rd_pos + i];
        end
        rd_pos = rd_pos + int'(cnt);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_bits    = '0;
      wr_pos         = 0;
      rd_pos         = 0;
      mismatch_count = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results are compared before new commands are queued in the same cycle.
      if (out_valid_i && out_ready_i) begin
        got_value  = out_data_i[bspu_pkg::VALUE_W-1:0];
        got_status = bspu_pkg::status_e'(out_data_i[bspu_pkg::VALUE_W +: bspu_pkg::STATUS_W]);
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: read_value %h status %0d", got_value, got_status);
        end else begin
          want = pending_results.pop_front();
          if (want.read_value !== got_value || want.status !== got_status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: read_value exp %h got %h, status exp %0d got %0d",
                       want.read_value, got_value, want.status, got_status);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(
          stream_result(bspu_pkg::op_e'(in_user_i[0]),
                        in_data_i[bspu_pkg::VALUE_W-1:0],
                        in_data_i[bspu_pkg::VALUE_W +: bspu_pkg::COUNT_W]));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= pending_results.size();
    end
  end

endmodule

/* sim/bit_stream_packer_unpacker_test.sv */
// Stimulus and verdict for the bit stream packer and unpacker.
module bit_stream_packer_unpacker_test;

  localparam int CAPACITY_BITS = 4096;
  localparam int RANDOM_ITEMS  = 1550;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        idle_on = 1'b1;
  int          fail_count;
  int          pending;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bit_stream_packer_unpacker #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bspu_stream_checker #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) stream_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver stalls at random unless idling is switched off.
  always @(posedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
  end

  // Offers one command and returns at the edge where it is accepted.
  task automatic send_command(input bspu_pkg::op_e op,
                              input logic [bspu_pkg::VALUE_W-1:0] val,
                              input logic [bspu_pkg::COUNT_W-1:0] cnt);
    while (idle_on && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, cnt, val};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Holds the sender back until every queued result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int                           n;
    int                           pick;
    bspu_pkg::op_e                op;
    logic [bspu_pkg::COUNT_W-1:0] cnt;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty buffer, bad counts, full-width fields and an exact drain.
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd1);
    send_command(bspu_pkg::OP_APPEND, 24'hFFFFFF, 5'd0);
    send_command(bspu_pkg::OP_APPEND, 24'hFFFFFF, 5'd25);
    send_command(bspu_pkg::OP_APPEND, 24'h000000, 5'd31);
    send_command(bspu_pkg::OP_READ,   24'hFFFFFF, 5'd0);
    send_command(bspu_pkg::OP_APPEND, 24'hFFFFFF, 5'd24);
    send_command(bspu_pkg::OP_APPEND, 24'h000001, 5'd1);
    send_command(bspu_pkg::OP_APPEND, 24'hFFFFFE, 5'd3);
    send_command(bspu_pkg::OP_APPEND, 24'hA5A5A5, 5'd24);
    send_command(bspu_pkg::OP_APPEND, 24'h5A5A5A, 5'd24);
    send_command(bspu_pkg::OP_APPEND, 24'hFFFFFF, 5'd13);
    send_command(bspu_pkg::OP_APPEND, 24'h000000, 5'd1);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd31);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd24);
    send_command(bspu_pkg::OP_READ,   24'hFFFFFF, 5'd1);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd3);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd25);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd24);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd24);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd13);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd2);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd1);
    send_command(bspu_pkg::OP_READ,   24'h000000, 5'd1);
    drain_results();

    // Random part: mostly short fields so that the buffer fills slowly and
    // the overflow boundary is reached partway through the run.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on <= !(n >= 500 && n < 800);
      if (n == 1000) drain_results();
      op   = ($urandom_range(0, 99) < 50) ? bspu_pkg::OP_APPEND : bspu_pkg::OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        cnt = bspu_pkg::COUNT_W'($urandom_range(0, 7));
        if (cnt != 0) cnt = cnt + 5'd24;
      end else if (pick < 55) begin
        cnt = bspu_pkg::COUNT_W'($urandom_range(1, 6));
      end else begin
        cnt = bspu_pkg::COUNT_W'($urandom_range(1, bspu_pkg::MAX_FIELD_BITS));
      end
      send_command(op, bspu_pkg::VALUE_W'($urandom()), cnt);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/bspu_pkg.sv
rtl/bspu_ram.sv
rtl/bspu_dp.sv
rtl/bspu_ctrl.sv
rtl/bit_stream_packer_unpacker.sv
sim/bspu_stream_checker.sv
sim/bit_stream_packer_unpacker_test.sv
